FILE: rtl/sle_pkg.sv
// shared types and codes of the sequential list engine
package sle_pkg;

    // width of length, position and count fields
    localparam int LEN_BITS = 7;

    // command codes
    typedef enum logic [2:0] {
        CMD_LOAD    = 3'd0,
        CMD_RESTORE = 3'd1,
        CMD_INSERT  = 3'd2,
        CMD_DELETE  = 3'd3,
        CMD_GET     = 3'd4,
        CMD_SEARCH  = 3'd5
    } t_cmd;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_BADPOS   = 2'd3
    } t_status;

    // registered outcome of the shared compare unit
    typedef struct packed {
        logic valid;
        logic hit;
    } t_match;

endpackage

FILE: rtl/sle_match.sv
// shared compare unit: registers one equality test and the word under test
module sle_match #(
    parameter int WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req,
    input  logic [WIDTH-1:0]   i_word,
    input  logic [WIDTH-1:0]   i_key,
    output sle_pkg::t_match    o_res,
    output logic [WIDTH-1:0]   o_word
);
    import sle_pkg::*;

    t_match             r_res;
    logic [WIDTH-1:0]   r_word;

    // compare stage, word carried along for the compaction write
    always_ff @(posedge i_clk) begin
        r_word <= i_word;
        if (!i_rst_n) begin
            r_res <= '0;
        end else begin
            r_res.valid <= i_req;
            r_res.hit   <= (i_word == i_key);
        end
    end

    assign o_res  = r_res;
    assign o_word = r_word;

endmodule

FILE: rtl/sequential_list_engine_top.sv
// top level of the sequential list engine: sequencer, list and backup memories
//
// A command is taken when start is high and busy is low. Load, the full and bad-position
// answers and the undefined codes respond at once and never raise busy; every other command
// holds busy high until the cycle that shows its last result. Each result is shown for one
// cycle with o_valid high and cannot be held off, so the receiver must take every beat.
// Every walk moves one entry per cycle, restore through the read port of the backup memory,
// insert, delete and search through the single read port of the list memory; only delete
// and search pass through the one shared compare unit. Search gives one beat per match, each
// held back until the next match or the end of the walk is seen, and a single not-found beat
// when nothing matches. Both memories start undefined; only entries below the stored
// lengths are ever read, so no clearing pass runs after reset.
module sequential_list_engine_top #(
    parameter int CAPACITY     = 64,
    parameter int ELEMENT_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [2:0]                      i_command,
    input  logic signed [31:0]              i_value,
    input  logic [sle_pkg::LEN_BITS-1:0]    i_position,
    output logic                            o_valid,
    output logic [1:0]                      o_status,
    output logic signed [31:0]              o_element,
    output logic [sle_pkg::LEN_BITS-1:0]    o_match_position,
    output logic [sle_pkg::LEN_BITS-1:0]    o_length,
    output logic [sle_pkg::LEN_BITS-1:0]    o_removed,
    output logic                            o_last
);
    import sle_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam logic [LEN_BITS-1:0] CAP_LEN = LEN_BITS'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESTORE,
        S_INSERT,
        S_WALK,
        S_GET_RD,
        S_GET_OUT
    } t_state;

    // memories and their read registers
    logic [ELEMENT_BITS-1:0]    lst_mem [CAPACITY];
    logic [ELEMENT_BITS-1:0]    bk_mem  [CAPACITY];
    logic [ELEMENT_BITS-1:0]    r_lst_rdata;
    logic [ELEMENT_BITS-1:0]    r_bk_rdata;

    logic                       lst_we;
    logic [IW-1:0]              lst_waddr;
    logic [ELEMENT_BITS-1:0]    lst_wdata;
    logic [IW-1:0]              lst_raddr;
    logic                       bk_we;
    logic [IW-1:0]              bk_waddr;
    logic [IW-1:0]              bk_raddr;

    // sequencer state
    t_state                     r_state, n_state;
    t_cmd                       r_cmd, n_cmd;
    logic [ELEMENT_BITS-1:0]    r_key, n_key;
    logic [LEN_BITS-1:0]        r_pos, n_pos;
    logic [LEN_BITS-1:0]        r_len, n_len;
    logic [LEN_BITS-1:0]        r_blen, n_blen;
    logic [LEN_BITS-1:0]        r_idx, n_idx;
    logic [LEN_BITS-1:0]        r_wr, n_wr;
    logic                       r_s1_vld, n_s1_vld;
    logic [LEN_BITS-1:0]        r_s1_idx, n_s1_idx;
    logic [LEN_BITS-1:0]        r_s2_pos, n_s2_pos;
    logic                       r_pend_vld, n_pend_vld;
    logic [LEN_BITS-1:0]        r_pend, n_pend;

    // result registers
    logic                       r_out_vld, n_out_vld;
    t_status                    r_status, n_status;
    logic signed [31:0]         r_element, n_element;
    logic [LEN_BITS-1:0]        r_mpos, n_mpos;
    logic [LEN_BITS-1:0]        r_olen, n_olen;
    logic [LEN_BITS-1:0]        r_removed, n_removed;
    logic                       r_last, n_last;

    logic [ELEMENT_BITS-1:0]    key_in;
    logic [LEN_BITS-1:0]        idx_m1;
    logic [LEN_BITS-1:0]        pos_m1;
    logic [LEN_BITS-1:0]        in_pos_m1;
    logic                       issue;
    t_match                     m_res;
    logic [ELEMENT_BITS-1:0]    m_word;

    assign key_in    = ELEMENT_BITS'(i_value);
    assign idx_m1    = r_idx - LEN_BITS'(1);
    assign pos_m1    = r_pos - LEN_BITS'(1);
    assign in_pos_m1 = i_position - LEN_BITS'(1);

    // shared compare unit for delete and search walks
    sle_match #(
        .WIDTH (ELEMENT_BITS)
    ) u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_s1_vld && (r_state == S_WALK)),
        .i_word  (r_lst_rdata),
        .i_key   (r_key),
        .o_res   (m_res),
        .o_word  (m_word)
    );

    // list memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (lst_we) begin
            lst_mem[lst_waddr] <= lst_wdata;
        end
        r_lst_rdata <= lst_mem[lst_raddr];
    end

    // backup memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (bk_we) begin
            bk_mem[bk_waddr] <= key_in;
        end
        r_bk_rdata <= bk_mem[bk_raddr];
    end

    // sequencer next state, memory controls and results
    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_key      = r_key;
        n_pos      = r_pos;
        n_len      = r_len;
        n_blen     = r_blen;
        n_idx      = r_idx;
        n_wr       = r_wr;
        n_s1_vld   = 1'b0;
        n_s1_idx   = r_s1_idx;
        n_s2_pos   = r_s1_idx + LEN_BITS'(1);
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        n_out_vld  = 1'b0;
        n_status   = ST_OK;
        n_element  = '0;
        n_mpos     = '0;
        n_olen     = r_len;
        n_removed  = '0;
        n_last     = 1'b1;
        lst_we     = 1'b0;
        lst_waddr  = r_s1_idx[IW-1:0];
        lst_wdata  = r_lst_rdata;
        lst_raddr  = r_idx[IW-1:0];
        bk_we      = 1'b0;
        bk_waddr   = r_blen[IW-1:0];
        bk_raddr   = r_idx[IW-1:0];
        issue      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd      = t_cmd'(i_command);
                    n_key      = key_in;
                    n_pos      = i_position;
                    n_idx      = '0;
                    n_wr       = '0;
                    n_pend_vld = 1'b0;
                    unique case (t_cmd'(i_command)) inside
                        CMD_LOAD: begin
                            n_out_vld = 1'b1;
                            if (r_blen >= CAP_LEN || r_len >= CAP_LEN) begin
                                n_status = ST_FULL;
                            end else begin
                                bk_we     = 1'b1;
                                lst_we    = 1'b1;
                                lst_waddr = r_len[IW-1:0];
                                lst_wdata = key_in;
                                n_len     = r_len + LEN_BITS'(1);
                                n_blen    = r_blen + LEN_BITS'(1);
                                n_olen    = r_len + LEN_BITS'(1);
                            end
                        end
                        CMD_RESTORE: begin
                            n_state = S_RESTORE;
                        end
                        CMD_INSERT: begin
                            if (r_len >= CAP_LEN) begin
                                n_out_vld = 1'b1;
                                n_status  = ST_FULL;
                            end else if (i_position == '0 ||
                                         i_position > r_len + LEN_BITS'(1)) begin
                                n_out_vld = 1'b1;
                                n_status  = ST_BADPOS;
                            end else begin
                                n_idx   = r_len;
                                n_state = S_INSERT;
                            end
                        end
                        CMD_DELETE, CMD_SEARCH: begin
                            n_state = S_WALK;
                        end
                        CMD_GET: begin
                            if (i_position == '0 || i_position > r_len) begin
                                n_out_vld = 1'b1;
                                n_status  = ST_BADPOS;
                            end else begin
                                lst_raddr = in_pos_m1[IW-1:0];
                                n_state   = S_GET_RD;
                            end
                        end
                        default: begin
                            n_out_vld = 1'b1;
                        end
                    endcase
                end
            end

            // copy backup into the list, read then write one entry a cycle
            S_RESTORE: begin
                issue = (r_idx < r_blen);
                if (issue) begin
                    bk_raddr = r_idx[IW-1:0];
                    n_s1_vld = 1'b1;
                    n_s1_idx = r_idx;
                    n_idx    = r_idx + LEN_BITS'(1);
                end
                if (r_s1_vld) begin
                    lst_we    = 1'b1;
                    lst_wdata = r_bk_rdata;
                end
                if (!issue && !r_s1_vld) begin
                    n_len     = r_blen;
                    n_olen    = r_blen;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            // shift entries up from the tail, then drop the new value in
            S_INSERT: begin
                issue = (r_idx >= r_pos);
                if (issue) begin
                    lst_raddr = idx_m1[IW-1:0];
                    n_s1_vld  = 1'b1;
                    n_s1_idx  = r_idx;
                    n_idx     = idx_m1;
                end
                if (r_s1_vld) begin
                    lst_we = 1'b1;
                end
                if (!issue && !r_s1_vld) begin
                    lst_we    = 1'b1;
                    lst_waddr = pos_m1[IW-1:0];
                    lst_wdata = r_key;
                    n_len     = r_len + LEN_BITS'(1);
                    n_olen    = r_len + LEN_BITS'(1);
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            // delete compacts, search reports each match once the next match or the end of the walk is seen
            S_WALK: begin
                issue = (r_idx < r_len);
                if (issue) begin
                    lst_raddr = r_idx[IW-1:0];
                    n_s1_vld  = 1'b1;
                    n_s1_idx  = r_idx;
                    n_idx     = r_idx + LEN_BITS'(1);
                end
                if (m_res.valid) begin
                    if (r_cmd == CMD_DELETE) begin
                        if (!m_res.hit) begin
                            lst_we    = 1'b1;
                            lst_waddr = r_wr[IW-1:0];
                            lst_wdata = m_word;
                            n_wr      = r_wr + LEN_BITS'(1);
                        end
                    end else if (m_res.hit) begin
                        if (r_pend_vld) begin
                            n_out_vld = 1'b1;
                            n_mpos    = r_pend;
                            n_last    = 1'b0;
                        end
                        n_pend_vld = 1'b1;
                        n_pend     = r_s2_pos;
                    end
                end
                if (!issue && !r_s1_vld && !m_res.valid) begin
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                    if (r_cmd == CMD_DELETE) begin
                        n_len     = r_wr;
                        n_olen    = r_wr;
                        n_removed = r_len - r_wr;
                        n_status  = (r_len != r_wr) ? ST_OK : ST_NOTFOUND;
                    end else if (r_pend_vld) begin
                        n_mpos = r_pend;
                    end else begin
                        n_status = ST_NOTFOUND;
                    end
                end
            end

            S_GET_RD: begin
                lst_raddr = pos_m1[IW-1:0];
                n_state   = S_GET_OUT;
            end

            S_GET_OUT: begin
                n_out_vld = 1'b1;
                n_element = 32'($signed(r_lst_rdata));
                n_state   = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered results
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_pos      <= n_pos;
        r_idx      <= n_idx;
        r_wr       <= n_wr;
        r_s1_idx   <= n_s1_idx;
        r_s2_pos   <= n_s2_pos;
        r_pend     <= n_pend;
        r_status   <= n_status;
        r_element  <= n_element;
        r_mpos     <= n_mpos;
        r_olen     <= n_olen;
        r_removed  <= n_removed;
        r_last     <= n_last;
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_len      <= '0;
            r_blen     <= '0;
            r_s1_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_len      <= n_len;
            r_blen     <= n_blen;
            r_s1_vld   <= n_s1_vld;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_out_vld;
    assign o_status         = r_status;
    assign o_element        = r_element;
    assign o_match_position = r_mpos;
    assign o_length         = r_olen;
    assign o_removed        = r_removed;
    assign o_last           = r_last;

`ifndef SYNTHESIS
    // a beat that is not the last one is shown while the engine is still busy
    a_mid_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> busy)
        else $error("non-final result beat without a busy walk behind it");

    // stored lengths never pass the capacity
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len <= CAP_LEN) && (r_blen <= CAP_LEN))
        else $error("list or backup length beyond capacity");

    // compaction write pointer never overtakes the read pointer
    a_wr_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_wr <= r_idx))
        else $error("delete write pointer ahead of read pointer");

    // a walk result only follows a drained compare pipeline or a new match
    a_walk_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && n_out_vld) |-> (m_res.valid || !r_s1_vld))
        else $error("walk result while compare pipeline still busy");
`endif

endmodule
